FILE: hw/rtl/actpwm_pkg.sv
// Package for the action color table PWM block.
// Holds the transfer structs, state encoding, op and status codes, duty helper.
// No dependencies.
package actpwm_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TAKE   = 2'd2;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_BAD_COUNT = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic [7:0] COLOR_PARAMS = 8'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] req_id;
        logic [7:0]  param_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] duty_red;
        logic [11:0] duty_green;
        logic [11:0] duty_blue;
        logic        duty_changed;
    } t_result;

    typedef struct packed {
        logic [31:0] id;
        logic [23:0] color;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_MOVE_RD,
        S_MOVE_WR
    } t_state;

    // 4095 - 16*c == 16*(255-c) + 15, i.e. inverted component with low nibble set
    function automatic logic [11:0] duty_of(input logic [7:0] comp);
        return {~comp, 4'hF};
    endfunction

endpackage

FILE: hw/rtl/actpwm_table.sv
// Entry table: action ids with their RGB colors.
// One write port, one read port with registered data. Uses actpwm_pkg.
module actpwm_table import actpwm_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/action_color_table_pwm_top.sv
// Action color table with three inverted 12-bit PWM duties.
// An unused op, bad count or full table ends in S_CHECK; other ops search the table in
//   S_SEARCH, and a remove that hits then moves the last entry in via S_MOVE_RD, S_MOVE_WR.
// Throughput: one item at a time; busy covers the whole search, paced by the table read port, and any move.
// Sync reset clears entry count, current color (black, duties 4095) and the sequencer;
//   table contents are not cleared. Results are not stalled: o_done strobes for one cycle.
module action_color_table_pwm_top import actpwm_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sequencer state and latched item
    t_state        r_state, n_state;
    t_item         r_item, n_item;

    // Table bookkeeping
    logic [CW-1:0] r_count, n_count;
    logic [23:0]   r_cur, n_cur;

    // Search pointers: r_addr is the next slot to read, r_cmp the slot whose data
    // arrives this cycle when r_pend is set.
    logic [CW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_cmp, n_cmp;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_slot, n_slot;

    // Result register
    logic          r_done, n_done;
    t_result       r_result, n_result;

    // Table port
    logic          tbl_we, tbl_re;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    t_entry        tbl_wdata, tbl_rdata;

    logic          hit, more, check_fin, fin;
    logic [2:0]    n_status;
    logic          n_changed;

    actpwm_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // Shared compare unit: one stored id against the requested id per cycle
    assign hit  = r_pend && (tbl_rdata.id == r_item.req_id);
    assign more = r_addr < r_count;

    assign check_fin = !(r_item.op == OP_ADD || r_item.op == OP_REMOVE ||
                         r_item.op == OP_TAKE) ||
                       (r_item.op == OP_ADD && (r_item.param_count != COLOR_PARAMS ||
                                                r_count >= CW'(TABLE_DEPTH)));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = check_fin ? S_IDLE : S_SEARCH;
            end
            S_SEARCH: begin
                if (hit && r_item.op == OP_REMOVE) begin
                    n_state = S_MOVE_RD;
                end else if (hit || !more) begin
                    n_state = S_IDLE;
                end
            end
            S_MOVE_RD: n_state = S_MOVE_WR;
            S_MOVE_WR: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_item    = r_item;
        n_count   = r_count;
        n_cur     = r_cur;
        n_addr    = r_addr;
        n_cmp     = r_cmp;
        n_pend    = 1'b0;
        n_slot    = r_slot;
        fin       = 1'b0;
        n_status  = ST_DONE;
        n_changed = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                end
            end
            S_CHECK: begin
                n_addr = '0;
                if (check_fin) begin
                    fin = 1'b1;
                    if (r_item.op == OP_ADD) begin
                        n_status = (r_item.param_count != COLOR_PARAMS) ? ST_BAD_COUNT
                                                                        : ST_FULL;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    case (r_item.op)
                        OP_ADD: begin
                            fin      = 1'b1;
                            n_status = ST_DUPLICATE;
                        end
                        OP_REMOVE: begin
                            n_count = r_count - CW'(1);
                            n_slot  = r_cmp;
                        end
                        OP_TAKE: begin
                            fin = 1'b1;
                            if (tbl_rdata.color != r_cur) begin
                                n_cur     = tbl_rdata.color;
                                n_changed = 1'b1;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end else if (more) begin
                    tbl_re    = 1'b1;
                    tbl_raddr = r_addr[AW-1:0];
                    n_cmp     = r_addr[AW-1:0];
                    n_pend    = 1'b1;
                    n_addr    = r_addr + CW'(1);
                end else begin
                    fin = 1'b1;
                    if (r_item.op == OP_ADD) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = r_count[AW-1:0];
                        tbl_wdata = '{id: r_item.req_id,
                                      color: {r_item.red, r_item.green, r_item.blue}};
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_MOVE_RD: begin
                // count already decremented: it now points at the last entry
                tbl_re    = 1'b1;
                tbl_raddr = r_count[AW-1:0];
            end
            S_MOVE_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_slot;
                tbl_wdata = tbl_rdata;
                fin       = 1'b1;
            end
            default: begin
                fin = 1'b0;
            end
        endcase

        n_done   = fin;
        n_result = r_result;
        if (fin) begin
            n_result = '{status:       n_status,
                         duty_red:     duty_of(n_cur[23:16]),
                         duty_green:   duty_of(n_cur[15:8]),
                         duty_blue:    duty_of(n_cur[7:0]),
                         duty_changed: n_changed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cur   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_addr   <= n_addr;
        r_cmp    <= n_cmp;
        r_slot   <= n_slot;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Entry count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
        (r_count == $past(r_count) - CW'(1)))
        else $error("entry count jumped");

    // Color only changes on a take
    a_changed_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.duty_changed) |-> (r_item.op == OP_TAKE))
        else $error("duty change outside take");

    // Accepted transfer makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accept");

    // A result is never produced while idle without a pending item
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != S_IDLE))
        else $error("result strobe without item");

endmodule

FILE: bench/action_color_table_pwm_top_test.sv
// Self-checking bench for action_color_table_pwm_top: add/remove/take on the action table.
// Directed items first, then random sequences; results are predicted and compared per field.
// Depends on actpwm_pkg and the action_color_table_pwm_top RTL.
`timescale 1ns / 1ps

module action_color_table_pwm_top_test;
    import actpwm_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    // Longer than the worst case from accept to o_done, with some margin on top.
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int POOL_SIZE     = 100;    // larger than the table, so it fills up

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [11:0] DUTY_OFF  = 12'd4095;
    localparam logic [11:0] DUTY_STEP = 12'd16;

    typedef struct {
        t_item       item;
        int unsigned idle_pct;
        bit          drain;     // hold this one back until the block has gone quiet
    } t_action_req;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   item = '0;
    logic    done;
    t_result result;

    action_color_table_pwm_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (item),
        .o_done  (done),
        .o_result(result)
    );

    // Half-period inversion: 10 ns clock.
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predicted table and applied color
    // ------------------------------------------------------------------
    logic [31:0] tbl_id    [TABLE_DEPTH];
    logic [23:0] tbl_color [TABLE_DEPTH];
    int          tbl_count = 0;
    logic [23:0] lit_color = 24'h000000;   // black after reset, all duties off

    t_action_req action_q[$];      // items still to be driven
    t_result     result_q[$];      // predicted results, oldest first

    int unsigned queued_n   = 0;
    int unsigned accepted_n = 0;
    int unsigned mismatch_n = 0;
    int unsigned cycle_n    = 0;
    int unsigned settle_n   = 0;
    int unsigned sender_idle = 15;
    bit          drain_next = 1'b0;
    bit          took = 1'b0;     // item on the bus was taken at the last rising edge

    logic [31:0] id_pool [POOL_SIZE];
    logic [23:0] palette [6] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                                 24'h00FF00, 24'h0000FF, 24'h808080};

    // Inverted duty: 4095 for a dark channel, 15 for a full one.
    function automatic logic [11:0] to_duty(input logic [7:0] c);
        return 12'(DUTY_OFF - DUTY_STEP * 12'(c));
    endfunction

    // Linear search over live entries; -1 when the id is absent.
    function automatic int find_entry(input logic [31:0] id);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_id[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic t_result apply_action(input t_item it);
        t_result r;
        int      slot;
        r = '0;
        r.status = ST_DONE;
        slot = find_entry(it.req_id);
        case (it.op)
            OP_ADD: begin
                // count check wins over full, full wins over duplicate
                if (it.param_count != COLOR_PARAMS) begin
                    r.status = ST_BAD_COUNT;
                end else if (tbl_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (slot >= 0) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    tbl_id[tbl_count]    = it.req_id;
                    tbl_color[tbl_count] = {it.red, it.green, it.blue};
                    tbl_count++;
                end
            end
            OP_REMOVE: begin
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    // last entry moves into the freed slot
                    tbl_count--;
                    tbl_id[slot]    = tbl_id[tbl_count];
                    tbl_color[slot] = tbl_color[tbl_count];
                end
            end
            OP_TAKE: begin
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (tbl_color[slot] != lit_color) begin
                    lit_color = tbl_color[slot];
                    r.duty_changed = 1'b1;
                end
            end
            default: ;  // unused op: no change, done
        endcase
        r.duty_red   = to_duty(lit_color[23:16]);
        r.duty_green = to_duty(lit_color[15:8]);
        r.duty_blue  = to_duty(lit_color[7:0]);
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, field, got, want);
        mismatch_n++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_action(input logic [1:0] op, input logic [31:0] id,
                               input logic [7:0] cnt, input logic [23:0] rgb);
        t_action_req req;
        req.item.op          = op;
        req.item.req_id      = id;
        req.item.param_count = cnt;
        req.item.red         = rgb[23:16];
        req.item.green       = rgb[15:8];
        req.item.blue        = rgb[7:0];
        req.idle_pct         = sender_idle;
        req.drain            = drain_next;
        drain_next           = 1'b0;
        action_q.push_back(req);
        queued_n++;
    endtask

    task automatic push_random_action();
        int unsigned pick;
        logic [1:0]  op;
        logic [31:0] id;
        logic [7:0]  cnt;
        logic [23:0] rgb;
        pick = $urandom_range(99);
        id   = ($urandom_range(99) < 95) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                         : $urandom();
        // half the colors from a small palette so same-color takes happen
        rgb  = ($urandom_range(1) == 1) ? palette[$urandom_range(5)] : 24'($urandom());
        cnt  = 8'($urandom());
        if (pick < 42) begin
            op  = OP_ADD;
            cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : COLOR_PARAMS;
        end else if (pick < 60) begin
            op = OP_REMOVE;
        end else if (pick < 92) begin
            op = OP_TAKE;
        end else if (pick < 95) begin
            op = OP_UNUSED;
        end else begin
            // noise: add, remove or take on an id that is almost surely absent
            op = 2'($urandom_range(2));
            id = $urandom();
        end
        push_action(op, id, cnt, rgb);
    endtask

    // ------------------------------------------------------------------
    // Driver: start/item change on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // transfer still pending: hold start and item
        end else if (action_q.size() == 0) begin
            start <= 1'b0;
        end else if (action_q[0].drain &&
                     (result_q.size() != 0 || busy || settle_n < SETTLE_CYCLES)) begin
            start    <= 1'b0;
            settle_n <= (result_q.size() != 0 || busy) ? 0 : settle_n + 1;
        end else if ($urandom_range(99) < action_q[0].idle_pct) begin
            start <= 1'b0;
        end else begin
            start    <= 1'b1;
            item     <= action_q[0].item;
            settle_n <= 0;
            action_q.pop_front();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results first, then the transfer of a new item
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_result want;
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("action_color_table_pwm_top_test: errors");
            $finish;
        end else if (rst_n) begin
            if (done) begin
                if (result_q.size() == 0) begin
                    flag_mismatch("unexpected result", 32'(result), 32'd0);
                end else begin
                    want = result_q.pop_front();
                    if (result.status !== want.status)
                        flag_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.duty_red !== want.duty_red)
                        flag_mismatch("duty_red", 32'(result.duty_red), 32'(want.duty_red));
                    if (result.duty_green !== want.duty_green)
                        flag_mismatch("duty_green", 32'(result.duty_green),
                                      32'(want.duty_green));
                    if (result.duty_blue !== want.duty_blue)
                        flag_mismatch("duty_blue", 32'(result.duty_blue), 32'(want.duty_blue));
                    if (result.duty_changed !== want.duty_changed)
                        flag_mismatch("duty_changed", 32'(result.duty_changed),
                                      32'(want.duty_changed));
                end
            end
            if (start && !busy) begin
                result_q.push_back(apply_action(item));
                accepted_n <= accepted_n + 1;
            end
        end
        took <= rst_n && start && !busy;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, three random phases, drain
    // ------------------------------------------------------------------
    initial begin
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom();

        // Directed: count checks, extreme ids and colors, each status code but full.
        push_action(OP_ADD,    32'h0000_0000, 8'd0,   24'h000000);  // bad count, zero
        push_action(OP_ADD,    32'h0000_0000, 8'd255, 24'hFFFFFF);  // bad count, all ones
        push_action(OP_TAKE,   32'h0000_0000, 8'd0,   24'h000000);  // take on empty table
        push_action(OP_REMOVE, 32'h0000_0000, 8'd0,   24'h000000);  // remove on empty table
        push_action(OP_ADD,    32'h0000_0000, COLOR_PARAMS, 24'h000000);
        push_action(OP_TAKE,   32'h0000_0000, 8'd0,   24'h000000);  // black again: no change
        push_action(OP_ADD,    32'hFFFF_FFFF, COLOR_PARAMS, 24'hFFFFFF);
        push_action(OP_ADD,    32'hFFFF_FFFF, COLOR_PARAMS, 24'h123456);  // duplicate
        push_action(OP_TAKE,   32'hFFFF_FFFF, 8'hFF,  24'hFFFFFF);  // full on, duties 15
        push_action(OP_TAKE,   32'hFFFF_FFFF, 8'hFF,  24'hFFFFFF);  // same color
        push_action(OP_ADD,    32'h5A5A_A5A5, COLOR_PARAMS, 24'hFF0000);
        push_action(OP_ADD,    32'hA5A5_5A5A, COLOR_PARAMS, 24'h00FF00);
        push_action(OP_ADD,    32'h8000_0001, COLOR_PARAMS, 24'h0000FF);
        push_action(OP_TAKE,   32'h5A5A_A5A5, 8'd0,   24'h000000);
        push_action(OP_TAKE,   32'hA5A5_5A5A, 8'd0,   24'h000000);
        push_action(OP_TAKE,   32'h8000_0001, 8'd0,   24'h000000);
        push_action(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF,  24'hFFFFFF);  // ignored op
        push_action(OP_REMOVE, 32'hFFFF_FFFF, 8'd0,   24'h000000);  // last entry moves in
        push_action(OP_TAKE,   32'hFFFF_FFFF, 8'd0,   24'h000000);  // now absent
        push_action(OP_TAKE,   32'h8000_0001, 8'd0,   24'h000000);  // found in moved slot
        push_action(OP_REMOVE, 32'h0000_0000, 8'd0,   24'h000000);  // first slot
        push_action(OP_REMOVE, 32'h8000_0001, 8'd0,   24'h000000);
        push_action(OP_ADD,    32'h1234_5678, 8'd2,   24'h010203);  // count one short
        push_action(OP_ADD,    32'h1234_5678, 8'd4,   24'h010203);  // count one over

        // Random phases: sender idles 15%, then 55%, then never.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle = (phase == 0) ? 15 : (phase == 1) ? 55 : 0;
            drain_next  = 1'b1;    // let the block go quiet before each phase
            if (phase == 0) begin
                // burst of well-formed adds drives the table toward full early
                for (int i = 0; i < 70; i++)
                    push_action(OP_ADD, id_pool[$urandom_range(POOL_SIZE - 1)],
                                COLOR_PARAMS, palette[$urandom_range(5)]);
            end
            for (int i = 0; i < ((phase == 0) ? 310 : 380); i++) push_random_action();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (accepted_n == queued_n);
        wait (result_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (result_q.size() != 0)
            flag_mismatch("missing result", 32'(result_q.size()), 32'd0);
        if (mismatch_n == 0) begin
            $display("action_color_table_pwm_top_test: clean");
        end else begin
            $display("action_color_table_pwm_top_test: errors");
        end
        $finish;
    end

endmodule
